[src/free_space_page_allocator_core_macros.svh]
// Assertion helpers for the allocator RTL.
`ifndef FREE_SPACE_PAGE_ALLOCATOR_CORE_MACROS_SVH
`define FREE_SPACE_PAGE_ALLOCATOR_CORE_MACROS_SVH

// Clocked check, disabled while reset is high.
`define FSPA_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("fspa assertion failed");

// Clocked check that also holds during reset.
`define FSPA_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("fspa assertion failed");

`endif

[src/fspa_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package fspa_pkg;
   localparam int GROUPS        = 8;
   localparam int GROUP_ENTRIES = 511;
   localparam int TOTAL_ENTRIES = GROUPS * GROUP_ENTRIES;
   localparam int ADDR_W        = $clog2(TOTAL_ENTRIES);
   localparam int FILL_W        = $clog2(GROUP_ENTRIES + 1);
   localparam int CIDX_W        = FILL_W + 1;
   localparam int GO_W          = $clog2(GROUPS + 1);
   localparam int GIDX_W        = (GROUPS > 1) ? $clog2(GROUPS) : 1;

   // two 16-bit header words per page
   localparam logic [15:0] PAGE_OVERHEAD = 16'd4;
   localparam logic [15:0] PAGE_BYTES_RST = 16'd4096;

   localparam logic [2:0] ST_REUSED    = 3'd0;
   localparam logic [2:0] ST_NEW_PAGE  = 3'd1;
   localparam logic [2:0] ST_NEW_GROUP = 3'd2;
   localparam logic [2:0] ST_TOO_LARGE = 3'd3;
   localparam logic [2:0] ST_FULL      = 3'd4;

   typedef struct packed {
      logic [15:0] free_space;
      logic [31:0] page;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);
endpackage
`default_nettype wire

[src/fspa_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
module fspa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

[src/free_space_page_allocator_core.sv]
// Time from request acceptance to rsp_valid grows with the group tops examined, the
//   sift-down or sift-up levels walked, and the search for a group with room.
// Requests are taken one at a time; the next is accepted in the cycle after the response is
//   registered, later while a held response is not taken.
// Reset: synchronous, active high. Clears group fills, groups_open=1, next_page=2,
//   page_bytes=4096. Heap RAM contents are not cleared; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
`include "free_space_page_allocator_core_macros.svh"
module free_space_page_allocator_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_wr_en,
   input  wire logic [15:0] csr_wr_data,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [15:0] req_required_bytes,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic      [31:0] rsp_page_number,
   output logic      [2:0]  rsp_status
);
   import fspa_pkg::*;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_SCAN   = 4'd1;  // pick next group with entries
   localparam logic [3:0] S_SCAN_W = 4'd2;  // top read back, check fit
   localparam logic [3:0] S_SD_L   = 4'd3;  // sift-down: read left child
   localparam logic [3:0] S_SD_LW  = 4'd4;
   localparam logic [3:0] S_SD_RW  = 4'd5;
   localparam logic [3:0] S_SD_CMP = 4'd6;
   localparam logic [3:0] S_MISS   = 4'd7;  // size check
   localparam logic [3:0] S_FIND   = 4'd8;  // first non-full group
   localparam logic [3:0] S_INS    = 4'd9;
   localparam logic [3:0] S_SU     = 4'd10; // sift-up: read parent
   localparam logic [3:0] S_SU_W   = 4'd11;
   localparam logic [3:0] S_OUT    = 4'd12;

   logic [3:0]        state_ff, state_in;
   logic [15:0]       req_ff, req_in;
   logic [GO_W-1:0]   g_ff, g_in;
   logic [ADDR_W-1:0] base_ff, base_in;
   logic [FILL_W-1:0] n_ff, n_in;
   logic [FILL_W-1:0] idx_ff, idx_in;
   logic [FILL_W-1:0] cidx_ff, cidx_in;
   entry_type         x_ff, x_in;       // entry being sifted (hole method)
   entry_type         cand_ff, cand_in; // larger child
   logic [31:0]       res_page_ff, res_page_in;
   logic [2:0]        res_status_ff, res_status_in;
   logic [FILL_W-1:0] fill_ff [GROUPS];
   logic [FILL_W-1:0] fill_wdata;
   logic              fill_we;
   logic [GO_W-1:0]   groups_open_ff, groups_open_in;
   logic [31:0]       next_page_ff, next_page_in;
   logic [15:0]       page_bytes_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [31:0]       rsp_page_ff, rsp_page_in;
   logic [2:0]        rsp_status_ff, rsp_status_in;

   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr, mem_raddr;
   entry_type         mem_wdata, mem_rdata;
   logic [ENTRY_W-1:0] mem_rbits;

   logic [GIDX_W-1:0] gi;
   logic [CIDX_W-1:0] left_idx;
   logic [FILL_W-1:0] parent_idx;
   logic [ADDR_W-1:0] cur_addr;
   logic [16:0]       need;

   assign gi         = g_ff[GIDX_W-1:0];
   assign left_idx   = {idx_ff, 1'b0} + CIDX_W'(1);
   assign parent_idx = (idx_ff - FILL_W'(1)) >> 1;
   assign cur_addr   = base_ff + ADDR_W'(idx_ff);
   assign need       = {1'b0, req_ff} + {1'b0, PAGE_OVERHEAD};
   assign mem_rdata  = entry_type'(mem_rbits);

   fspa_ram #(.WIDTH(ENTRY_W), .DEPTH(TOTAL_ENTRIES)) u_heap_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rbits)
   );

   assign req_ready       = (state_ff == S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_page_number = rsp_page_ff;
   assign rsp_status      = rsp_status_ff;

   always_comb begin
      state_in       = state_ff;
      req_in         = req_ff;
      g_in           = g_ff;
      base_in        = base_ff;
      n_in           = n_ff;
      idx_in         = idx_ff;
      cidx_in        = cidx_ff;
      x_in           = x_ff;
      cand_in        = cand_ff;
      res_page_in    = res_page_ff;
      res_status_in  = res_status_ff;
      groups_open_in = groups_open_ff;
      next_page_in   = next_page_ff;
      fill_we        = 1'b0;
      fill_wdata     = fill_ff[gi];
      mem_we         = 1'b0;
      mem_waddr      = cur_addr;
      mem_wdata      = x_ff;
      mem_raddr      = base_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_page_in    = rsp_page_ff;
      rsp_status_in  = rsp_status_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in   = req_required_bytes;
               g_in     = '0;
               base_in  = '0;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (g_ff >= groups_open_ff) begin
               state_in = S_MISS;
            end else if (fill_ff[gi] != '0) begin
               mem_raddr = base_ff;
               state_in  = S_SCAN_W;
            end else begin
               g_in    = g_ff + GO_W'(1);
               base_in = base_ff + ADDR_W'(GROUP_ENTRIES);
            end
         end
         S_SCAN_W: begin
            if (mem_rdata.free_space >= req_ff) begin
               x_in.free_space = mem_rdata.free_space - req_ff;
               x_in.page       = mem_rdata.page;
               res_page_in     = mem_rdata.page;
               res_status_in   = ST_REUSED;
               n_in            = fill_ff[gi];
               idx_in          = '0;
               state_in        = S_SD_L;
            end else begin
               g_in     = g_ff + GO_W'(1);
               base_in  = base_ff + ADDR_W'(GROUP_ENTRIES);
               state_in = S_SCAN;
            end
         end
         S_SD_L: begin
            if (left_idx >= CIDX_W'(n_ff)) begin
               mem_we   = 1'b1;
               state_in = S_OUT;
            end else begin
               mem_raddr = base_ff + ADDR_W'(left_idx);
               cidx_in   = left_idx[FILL_W-1:0];
               state_in  = S_SD_LW;
            end
         end
         S_SD_LW: begin
            cand_in = mem_rdata;
            if ((CIDX_W'(cidx_ff) + CIDX_W'(1)) < CIDX_W'(n_ff)) begin
               mem_raddr = base_ff + ADDR_W'(cidx_ff) + ADDR_W'(1);
               state_in  = S_SD_RW;
            end else begin
               state_in = S_SD_CMP;
            end
         end
         S_SD_RW: begin
            if (mem_rdata.free_space > cand_ff.free_space) begin
               cand_in = mem_rdata;
               cidx_in = cidx_ff + FILL_W'(1);
            end
            state_in = S_SD_CMP;
         end
         S_SD_CMP: begin
            mem_we = 1'b1;
            if (cand_ff.free_space > x_ff.free_space) begin
               mem_wdata = cand_ff;
               idx_in    = cidx_ff;
               state_in  = S_SD_L;
            end else begin
               state_in = S_OUT;
            end
         end
         S_MISS: begin
            if (need > {1'b0, page_bytes_ff}) begin
               res_page_in   = '0;
               res_status_in = ST_TOO_LARGE;
               state_in      = S_OUT;
            end else begin
               g_in     = '0;
               base_in  = '0;
               state_in = S_FIND;
            end
         end
         S_FIND: begin
            if (g_ff >= groups_open_ff) begin
               if (groups_open_ff >= GO_W'(GROUPS)) begin
                  res_page_in   = '0;
                  res_status_in = ST_FULL;
                  state_in      = S_OUT;
               end else begin
                  groups_open_in = groups_open_ff + GO_W'(1);
                  res_status_in  = ST_NEW_GROUP;
                  state_in       = S_INS;
               end
            end else if (fill_ff[gi] < FILL_W'(GROUP_ENTRIES)) begin
               res_status_in = ST_NEW_PAGE;
               state_in      = S_INS;
            end else begin
               g_in    = g_ff + GO_W'(1);
               base_in = base_ff + ADDR_W'(GROUP_ENTRIES);
            end
         end
         S_INS: begin
            res_page_in     = next_page_ff;
            next_page_in    = next_page_ff
                              + ((res_status_ff == ST_NEW_GROUP) ? 32'd2 : 32'd1);
            x_in.page       = next_page_ff;
            x_in.free_space = page_bytes_ff - req_ff - PAGE_OVERHEAD;
            idx_in          = fill_ff[gi];
            fill_we         = 1'b1;
            fill_wdata      = fill_ff[gi] + FILL_W'(1);
            state_in        = S_SU;
         end
         S_SU: begin
            if (idx_ff == '0) begin
               mem_we   = 1'b1;
               state_in = S_OUT;
            end else begin
               mem_raddr = base_ff + ADDR_W'(parent_idx);
               state_in  = S_SU_W;
            end
         end
         S_SU_W: begin
            mem_we = 1'b1;
            if (x_ff.free_space > mem_rdata.free_space) begin
               mem_wdata = mem_rdata;
               idx_in    = parent_idx;
               state_in  = S_SU;
            end else begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_page_in   = res_page_ff;
               rsp_status_in = res_status_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         groups_open_ff <= GO_W'(1);
         next_page_ff   <= 32'd2;
         page_bytes_ff  <= PAGE_BYTES_RST;
         rsp_valid_ff   <= 1'b0;
         for (int k = 0; k < GROUPS; k++) begin
            fill_ff[k] <= '0;
         end
      end else begin
         state_ff       <= state_in;
         groups_open_ff <= groups_open_in;
         next_page_ff   <= next_page_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (csr_wr_en) begin
            page_bytes_ff <= csr_wr_data;
         end
         if (fill_we) begin
            fill_ff[gi] <= fill_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      req_ff        <= req_in;
      g_ff          <= g_in;
      base_ff       <= base_in;
      n_ff          <= n_in;
      idx_ff        <= idx_in;
      cidx_ff       <= cidx_in;
      x_ff          <= x_in;
      cand_ff       <= cand_in;
      res_page_ff   <= res_page_in;
      res_status_ff <= res_status_in;
      rsp_page_ff   <= rsp_page_in;
      rsp_status_ff <= rsp_status_in;
   end

   `FSPA_ASSERT(a_err_page_zero, clock, reset,
      rsp_valid && (rsp_status == ST_TOO_LARGE || rsp_status == ST_FULL) |-> rsp_page_number == '0)
   `FSPA_ASSERT_ALWAYS(a_groups_range, clock,
      !reset |=> (groups_open_ff >= GO_W'(1) && groups_open_ff <= GO_W'(GROUPS)))
   `FSPA_ASSERT(a_su_not_root, clock, reset,
      state_ff == S_SU_W |-> idx_ff != '0)
   `FSPA_ASSERT(a_busy_not_ready, clock, reset,
      state_ff != S_IDLE |-> !req_ready)
endmodule
`default_nettype wire
